@@ rtl/core/tpca_pkg.sv @@
// ----------------------------------------------------------------------------
// tpca_pkg
// Shared widths, register codes, configuration, command and status types for
// the touch point calibration and averaging unit.
// ----------------------------------------------------------------------------
package tpca_pkg;

  localparam int RAW_W      = 12;
  localparam int RES_W      = 13;
  localparam int ORIENT_W   = 3;
  localparam int PROD_W     = RAW_W + RES_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_W      = ((PROD_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int DIV_CYC    = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYC + 1);

  localparam int AVG_DEPTH_DEF = 4;

  localparam int APB_DW = 32;
  localparam int APB_AW = 5;

  localparam int ORIENT_SWAP  = 0;
  localparam int ORIENT_INV_X = 1;
  localparam int ORIENT_INV_Y = 2;

  localparam logic [RAW_W-1:0]    X_MIN_RST  = RAW_W'(200);
  localparam logic [RAW_W-1:0]    X_MAX_RST  = RAW_W'(3800);
  localparam logic [RAW_W-1:0]    Y_MIN_RST  = RAW_W'(200);
  localparam logic [RAW_W-1:0]    Y_MAX_RST  = RAW_W'(3800);
  localparam logic [RES_W-1:0]    WIDTH_RST  = RES_W'(480);
  localparam logic [RES_W-1:0]    HEIGHT_RST = RES_W'(320);
  localparam logic [ORIENT_W-1:0] ORIENT_RST = '0;

  typedef enum logic [2:0] {
    REG_X_MIN  = 3'd0,
    REG_X_MAX  = 3'd1,
    REG_Y_MIN  = 3'd2,
    REG_Y_MAX  = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5,
    REG_ORIENT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [RAW_W-1:0]    x_min;
    logic [RAW_W-1:0]    x_max;
    logic [RAW_W-1:0]    y_min;
    logic [RAW_W-1:0]    y_max;
    logic [RES_W-1:0]    width;
    logic [RES_W-1:0]    height;
    logic [ORIENT_W-1:0] orient;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULT,
    ST_DIV_SCALE,
    ST_WAIT_SCALE,
    ST_UPDATE,
    ST_DIV_AVG,
    ST_WAIT_AVG,
    ST_HOLD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mult;
    logic div_start;
    logic div_avg;
    logic update;
    logic release_clr;
    logic hold;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic touched;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/tpca_regs.sv @@
// ----------------------------------------------------------------------------
// tpca_regs
// APB register bank holding the calibration limits, resolution and
// orientation settings.
// ----------------------------------------------------------------------------
module tpca_regs
  import tpca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_min  <= X_MIN_RST;
      cfg.x_max  <= X_MAX_RST;
      cfg.y_min  <= Y_MIN_RST;
      cfg.y_max  <= Y_MAX_RST;
      cfg.width  <= WIDTH_RST;
      cfg.height <= HEIGHT_RST;
      cfg.orient <= ORIENT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_X_MIN:  cfg.x_min  <= pwdata[RAW_W-1:0];
        REG_X_MAX:  cfg.x_max  <= pwdata[RAW_W-1:0];
        REG_Y_MIN:  cfg.y_min  <= pwdata[RAW_W-1:0];
        REG_Y_MAX:  cfg.y_max  <= pwdata[RAW_W-1:0];
        REG_WIDTH:  cfg.width  <= pwdata[RES_W-1:0];
        REG_HEIGHT: cfg.height <= pwdata[RES_W-1:0];
        REG_ORIENT: cfg.orient <= pwdata[ORIENT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_X_MIN:  prdata = APB_DW'(cfg.x_min);
      REG_X_MAX:  prdata = APB_DW'(cfg.x_max);
      REG_Y_MIN:  prdata = APB_DW'(cfg.y_min);
      REG_Y_MAX:  prdata = APB_DW'(cfg.y_max);
      REG_WIDTH:  prdata = APB_DW'(cfg.width);
      REG_HEIGHT: prdata = APB_DW'(cfg.height);
      REG_ORIENT: prdata = APB_DW'(cfg.orient);
      default:    prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/tpca_div.sv @@
// ----------------------------------------------------------------------------
// tpca_div
// Iterative restoring divider that retires two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tpca_div
  import tpca_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [RAW_W-1:0] divisor,
  output logic             busy,
  output logic [DIV_W-1:0] quotient
);

  logic [RAW_W-1:0]     rem;
  logic [RAW_W-1:0]     den;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RAW_W-1:0]     rem_next;
  logic [DIV_W-1:0]     quo_next;
  logic [RAW_W:0]       trial;

  always_comb begin
    rem_next = rem;
    quo_next = quotient;
    trial    = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial    = {rem_next, quo_next[DIV_W-1]};
      quo_next = {quo_next[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial       = trial - {1'b0, den};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[RAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_CYC);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= quo_next;
    end
  end

endmodule

@@ rtl/core/tpca_datapath.sv @@
// ----------------------------------------------------------------------------
// tpca_datapath
// Offset, scale, saturate and invert for both axes, the sliding window with
// running sums, the held point and the result register.
// ----------------------------------------------------------------------------
module tpca_datapath
  import tpca_pkg::*;
#(
  parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  cmd_t             cmd,
  output status_t          status,
  input  logic             in_touched,
  input  logic [RAW_W-1:0] in_raw_x,
  input  logic [RAW_W-1:0] in_raw_y,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_pressed,
  output logic [RES_W-1:0] out_pos_x,
  output logic [RES_W-1:0] out_pos_y
);

  localparam int FILL_W = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W  = RES_W + $clog2(AVG_DEPTH + 1);

  logic              touched;
  logic [RAW_W-1:0]  raw_x;
  logic [RAW_W-1:0]  raw_y;
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  logic [RES_W-1:0]  hist_x [AVG_DEPTH];
  logic [RES_W-1:0]  hist_y [AVG_DEPTH];
  logic [SUM_W-1:0]  sum_x;
  logic [SUM_W-1:0]  sum_y;
  logic [FILL_W-1:0] fill;
  logic [RES_W-1:0]  held_x;
  logic [RES_W-1:0]  held_y;

  logic [RAW_W-1:0] sel_x, sel_y, off_x, off_y, span_x, span_y;
  logic             zero_x, zero_y, full;
  logic [DIV_W-1:0] dvd_x, dvd_y, quo_x, quo_y;
  logic [RAW_W-1:0] dvs_x, dvs_y;
  logic             busy_x, busy_y;
  logic [RES_W-1:0] sat_x, sat_y, clip_x, clip_y, cx, cy;

  always_comb begin
    sel_x  = cfg.orient[ORIENT_SWAP] ? raw_y : raw_x;
    sel_y  = cfg.orient[ORIENT_SWAP] ? raw_x : raw_y;
    off_x  = (sel_x > cfg.x_min) ? sel_x - cfg.x_min : '0;
    off_y  = (sel_y > cfg.y_min) ? sel_y - cfg.y_min : '0;
    span_x = cfg.x_max - cfg.x_min;
    span_y = cfg.y_max - cfg.y_min;
    zero_x = (cfg.x_max <= cfg.x_min) || (cfg.width == '0);
    zero_y = (cfg.y_max <= cfg.y_min) || (cfg.height == '0);
    full   = (fill == FILL_W'(AVG_DEPTH));

    dvd_x = cmd.div_avg ? DIV_W'(sum_x) : DIV_W'(prod_x);
    dvd_y = cmd.div_avg ? DIV_W'(sum_y) : DIV_W'(prod_y);
    dvs_x = cmd.div_avg ? RAW_W'(fill) : span_x;
    dvs_y = cmd.div_avg ? RAW_W'(fill) : span_y;

    sat_x  = (quo_x > DIV_W'(cfg.width)) ? cfg.width : quo_x[RES_W-1:0];
    sat_y  = (quo_y > DIV_W'(cfg.height)) ? cfg.height : quo_y[RES_W-1:0];
    clip_x = zero_x ? '0 : sat_x;
    clip_y = zero_y ? '0 : sat_y;
    cx     = cfg.orient[ORIENT_INV_X] ? cfg.width - clip_x : clip_x;
    cy     = cfg.orient[ORIENT_INV_Y] ? cfg.height - clip_y : clip_y;
  end

  tpca_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd_x),
    .divisor  (dvs_x),
    .busy     (busy_x),
    .quotient (quo_x)
  );

  tpca_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd_y),
    .divisor  (dvs_y),
    .busy     (busy_y),
    .quotient (quo_y)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      touched <= in_touched;
      raw_x   <= in_raw_x;
      raw_y   <= in_raw_y;
    end
    if (cmd.mult) begin
      prod_x <= PROD_W'(off_x) * PROD_W'(cfg.width);
      prod_y <= PROD_W'(off_y) * PROD_W'(cfg.height);
    end
    if (cmd.update) begin
      for (int i = AVG_DEPTH - 1; i > 0; i--) begin
        hist_x[i] <= hist_x[i-1];
        hist_y[i] <= hist_y[i-1];
      end
      hist_x[0] <= cx;
      hist_y[0] <= cy;
    end
    if (cmd.load_out) begin
      out_pressed <= touched;
      out_pos_x   <= held_x;
      out_pos_y   <= held_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      held_x    <= '0;
      held_y    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.release_clr) begin
        fill  <= '0;
        sum_x <= '0;
        sum_y <= '0;
      end else if (cmd.update) begin
        if (full) begin
          sum_x <= sum_x + SUM_W'(cx) - SUM_W'(hist_x[AVG_DEPTH-1]);
          sum_y <= sum_y + SUM_W'(cy) - SUM_W'(hist_y[AVG_DEPTH-1]);
        end else begin
          sum_x <= sum_x + SUM_W'(cx);
          sum_y <= sum_y + SUM_W'(cy);
          fill  <= fill + 1'b1;
        end
      end
      if (cmd.hold) begin
        held_x <= quo_x[RES_W-1:0];
        held_y <= quo_y[RES_W-1:0];
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.touched  = touched;
  assign status.div_busy = busy_x || busy_y;
  assign status.out_free = !out_valid || out_ready;

endmodule

@@ rtl/core/tpca_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpca_ctrl
// Sequencer that steps one sample through scaling, window update, averaging
// and hand-off to the result register; a released sample clears the window instead.
// ----------------------------------------------------------------------------
module tpca_ctrl
  import tpca_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_MULT;
        end
      end
      ST_MULT: begin
        if (status.touched) begin
          cmd.mult   = 1'b1;
          state_next = ST_DIV_SCALE;
        end else begin
          cmd.release_clr = 1'b1;
          state_next      = ST_FINISH;
        end
      end
      ST_DIV_SCALE: begin
        cmd.div_start = 1'b1;
        state_next    = ST_WAIT_SCALE;
      end
      ST_WAIT_SCALE: begin
        if (!status.div_busy) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_DIV_AVG;
      end
      ST_DIV_AVG: begin
        cmd.div_start = 1'b1;
        cmd.div_avg   = 1'b1;
        state_next    = ST_WAIT_AVG;
      end
      ST_WAIT_AVG: begin
        cmd.div_avg = 1'b1;
        if (!status.div_busy) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        cmd.hold   = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/core/touch_point_calibrate_average_unit.sv @@
// A pressed sample is scaled, windowed, averaged and held, using two passes
// through the shared pair of two-bit-per-cycle dividers; a released sample empties the window.
// Either result is then loaded, and a new sample is accepted only after that load.
// The result register lets the next sample be accepted while a result waits.
// Synchronous reset restores the register defaults, empties the window and zeroes the held point.
// ----------------------------------------------------------------------------
// touch_point_calibrate_average_unit
// Calibrates raw touch samples to screen coordinates and averages them over a
// sliding window of recent points.
// ----------------------------------------------------------------------------
module touch_point_calibrate_average_unit
  import tpca_pkg::*;
#(
  parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,  // raw_x[11:0], raw_y[23:12]
  input  logic              s_tuser,  // touched[0]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,  // pos_x[12:0], pos_y[25:13], zero[31:26]
  output logic              m_tuser   // pressed[0]
);

  cfg_t             cfg;
  cmd_t             cmd;
  status_t          status;
  logic [RES_W-1:0] pos_x;
  logic [RES_W-1:0] pos_y;

  assign pready = 1'b1;

  tpca_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  tpca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tpca_datapath #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .in_touched  (s_tuser),
    .in_raw_x    (s_tdata[RAW_W-1:0]),
    .in_raw_y    (s_tdata[2*RAW_W-1:RAW_W]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_pressed (m_tuser),
    .out_pos_x   (pos_x),
    .out_pos_y   (pos_y)
  );

  assign m_tdata = {(32 - 2 * RES_W)'(0), pos_y, pos_x};

endmodule
